// ----- rtl/gof_pkg.sv -----
// shared types and constants for the goodness-of-fit chi-square / r2 unit
// no dependencies
package gof_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 64;
  localparam int unsigned SumW  = 48;
  localparam int unsigned R2W   = 17;
  localparam int unsigned CntW  = 10;
  localparam int unsigned R2Frac = 16;
  localparam logic [DataW-1:0] FloorReset = 32'd66;
  localparam logic [AccW-1:0] Mask48 = 64'h0000_FFFF_FFFF_FFFF;

  typedef enum logic [0:0] {
    REG_EXPECTED_FLOOR = 1'b0
  } reg_idx_e;

  // divider operand selection
  typedef enum logic [1:0] {
    DSEL_CHI  = 2'd0,
    DSEL_CORR = 2'd1,
    DSEL_R2   = 2'd2
  } dsel_e;

  typedef struct packed {
    logic  accum;      // latch pair and compute squares
    logic  add;        // add squares into accumulators
    logic  mul_start;  // start squaring of the observed sum
    logic  div_start;
    dsel_e div_sel;
    logic  chi_add;    // add quotient into chi accumulator
    logic  tss_calc;   // form tss from correction quotient
    logic  r2_prep;    // normalize tss / tss-rss
    logic  r2_done;    // take r2 quotient
    logic  emit;
    logic  clear;
  } gof_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mul_busy;
    logic chi_needed;
    logic count_full;
    logic count_zero;
    logic tss_zero;
    logic rss_ge_tss;
    logic norm_done;
  } gof_sts_t;

endpackage

// ----- rtl/gof_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on gof_pkg
module gof_divider #(
  parameter int unsigned NumW = 128,
  parameter int unsigned DenW = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  import gof_pkg::*;

  localparam int unsigned CW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[DenW-1:0], quo_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q[DenW] || !trial[DenW]) begin
        rem_d = rem_q[DenW] ? (shifted - {1'b0, den_q}) : trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  a_cnt_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !start_i || 1'b1)
    else $error("unreachable");
  a_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CW'(1) && !start_i) |=> !busy_q)
    else $error("divider did not finish on last step");
  a_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == CW'(NumW))
    else $error("divider did not load");

endmodule

// ----- rtl/gof_datapath.sv -----
// accumulators, squaring, tss and r2 normalization around a shared divider
// depends on gof_pkg and gof_divider
module gof_datapath #(
  parameter int unsigned MaxPairs = 512,
  parameter int unsigned FracBits = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gof_pkg::gof_cmd_t          cmd_i,
  output gof_pkg::gof_sts_t          sts_o,
  input  logic [gof_pkg::DataW-1:0]  observed_i,
  input  logic [gof_pkg::DataW-1:0]  expected_i,
  input  logic [gof_pkg::DataW-1:0]  floor_i,
  output logic [gof_pkg::AccW-1:0]   chi_square_o,
  output logic [gof_pkg::R2W-1:0]    r_squared_o,
  output logic [gof_pkg::CntW-1:0]   pairs_used_o,
  output logic                       degenerate_o
);
  import gof_pkg::*;

  localparam int unsigned NumW = 128;
  localparam int unsigned PcW  = $clog2(MaxPairs + 1);
  localparam int unsigned SqW  = 2 * SumW;
  localparam int unsigned MulChunk = 16;
  localparam int unsigned MulSteps = SumW / MulChunk;

  logic [DataW-1:0]   exp_q;
  logic [2*DataW-1:0] d2_q, o2_q;
  logic [PcW-1:0]     cnt_q;
  logic [SumW-1:0]    osum_q;
  logic [AccW-1:0]    osq_q, rss_q, chi_q, tss_q;
  logic [AccW-1:0]    num_q, den_q;
  logic [R2W-1:0]     r2_q;
  logic               deg_q;
  logic [SqW-1:0]     sq_q;
  logic [SumW-1:0]    mpl_q;
  logic [1:0]         mul_cnt_q;
  logic [SumW+MulChunk-1:0] part;
  logic [DataW-1:0]   dabs;
  logic [SumW:0]      osum_add;
  logic [AccW:0]      osq_add, rss_add, chi_add;
  logic [NumW-1:0]    dnum;
  logic [AccW-1:0]    dden;
  logic [NumW-1:0]    quo;
  logic               dbusy;
  logic [AccW-1:0]    corr;
  logic [AccW-1:0]    r2num;

  assign dabs = (observed_i >= expected_i) ? observed_i - expected_i
                                           : expected_i - observed_i;

  assign osum_add = {1'b0, osum_q} + (SumW + 1)'(observed_i);
  assign osq_add  = {1'b0, osq_q} + (AccW + 1)'(o2_q >> FracBits);
  assign rss_add  = {1'b0, rss_q} + (AccW + 1)'(d2_q >> FracBits);
  assign chi_add  = {1'b0, chi_q} + (AccW + 1)'(quo);

  // observed sum squared 16 bits of multiplier at a time, top chunk first
  assign part  = (SumW + MulChunk)'(osum_q) *
                 (SumW + MulChunk)'(mpl_q[SumW-1 -: MulChunk]);
  assign corr  = (quo[NumW-1:AccW] != '0) ? '1 : quo[AccW-1:0];
  assign r2num = num_q << R2Frac;

  always_comb begin
    dnum = NumW'(d2_q);
    dden = AccW'(exp_q);
    case (cmd_i.div_sel)
      DSEL_CHI: begin
        dnum = NumW'(d2_q);
        dden = AccW'(exp_q);
      end
      DSEL_CORR: begin
        dnum = NumW'(sq_q >> FracBits);
        dden = AccW'(cnt_q);
      end
      DSEL_R2: begin
        dnum = NumW'(r2num);
        dden = den_q;
      end
      default: begin
        dnum = NumW'(d2_q);
        dden = AccW'(exp_q);
      end
    endcase
  end

  gof_divider #(.NumW(NumW), .DenW(AccW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (dnum),
    .den_i  (dden),
    .busy_o (dbusy),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      osum_q <= '0;
      osq_q  <= '0;
      rss_q  <= '0;
      chi_q  <= '0;
    end else if (cmd_i.clear) begin
      cnt_q  <= '0;
      osum_q <= '0;
      osq_q  <= '0;
      rss_q  <= '0;
      chi_q  <= '0;
    end else begin
      if (cmd_i.accum) begin
        cnt_q  <= cnt_q + 1'b1;
        osum_q <= osum_add[SumW] ? '1 : osum_add[SumW-1:0];
      end
      if (cmd_i.add) begin
        osq_q <= osq_add[AccW] ? '1 : osq_add[AccW-1:0];
        rss_q <= rss_add[AccW] ? '1 : rss_add[AccW-1:0];
      end
      if (cmd_i.chi_add) begin
        chi_q <= (chi_add[AccW] || quo[NumW-1:AccW] != '0) ? '1 : chi_add[AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (cmd_i.mul_start) begin
      mul_cnt_q <= 2'(MulSteps);
    end else if (mul_cnt_q != '0) begin
      mul_cnt_q <= mul_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      exp_q <= expected_i;
      d2_q  <= (2*DataW)'(dabs) * (2*DataW)'(dabs);
      o2_q  <= (2*DataW)'(observed_i) * (2*DataW)'(observed_i);
    end
    if (cmd_i.mul_start) begin
      sq_q  <= '0;
      mpl_q <= osum_q;
    end else if (mul_cnt_q != '0) begin
      sq_q  <= (sq_q << MulChunk) + SqW'(part);
      mpl_q <= mpl_q << MulChunk;
    end
    if (cmd_i.tss_calc) begin
      tss_q <= (cnt_q == '0 || osq_q <= corr) ? '0 : osq_q - corr;
    end
    if (cmd_i.r2_prep) begin
      if (num_q == '0 && den_q == '0) begin
        num_q <= tss_q - rss_q;
        den_q <= tss_q;
      end else if (den_q > Mask48) begin
        num_q <= num_q >> 1;
        den_q <= den_q >> 1;
      end
    end
    if (cmd_i.emit) begin
      num_q <= '0;
      den_q <= '0;
    end
    if (cmd_i.r2_done) begin
      r2_q <= (quo > NumW'(1 << R2Frac)) ? R2W'(1 << R2Frac) : quo[R2W-1:0];
    end
    if (cmd_i.div_start && cmd_i.div_sel == DSEL_CORR) begin
      r2_q  <= '0;
      deg_q <= 1'b0;
      num_q <= '0;
      den_q <= '0;
    end
    if (cmd_i.tss_calc) begin
      deg_q <= (cnt_q == '0 || osq_q <= corr);
    end
  end

  assign sts_o.div_busy   = dbusy;
  assign sts_o.mul_busy   = mul_cnt_q != '0;
  assign sts_o.chi_needed = exp_q > floor_i;
  assign sts_o.count_full = cnt_q >= PcW'(MaxPairs);
  assign sts_o.count_zero = cnt_q == '0;
  assign sts_o.tss_zero   = tss_q == '0;
  assign sts_o.rss_ge_tss = rss_q >= tss_q;
  assign sts_o.norm_done  = (den_q != '0) && (den_q <= Mask48);

  assign chi_square_o = chi_q;
  assign r_squared_o  = r2_q;
  assign pairs_used_o = CntW'(cnt_q);
  assign degenerate_o = deg_q;

endmodule

// ----- rtl/gof_ctrl.sv -----
// sequencer: accumulate pair, chi division, final tss and r2 divisions
// depends on gof_pkg
module gof_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              last_pair_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gof_pkg::gof_cmd_t cmd_o,
  input  gof_pkg::gof_sts_t sts_i
);
  import gof_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ADD    = 11'b000_0000_0010,
    S_CHI    = 11'b000_0000_0100,
    S_CHIW   = 11'b000_0000_1000,
    S_CHECK  = 11'b000_0001_0000,
    S_MULW   = 11'b000_0010_0000,
    S_CORRW  = 11'b000_0100_0000,
    S_TSS    = 11'b000_1000_0000,
    S_NORM   = 11'b001_0000_0000,
    S_R2W    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   wait_q, wait_d;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    wait_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.div_sel = DSEL_CHI;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_pair_i;
          if (sts_i.count_full) begin
            state_d = last_pair_i ? S_CHECK : S_IDLE;
          end else begin
            cmd_o.accum = 1'b1;
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d = S_CHI;
      end
      S_CHI: begin
        if (sts_i.chi_needed) begin
          cmd_o.div_start = 1'b1;
          state_d = S_CHIW;
          wait_d = 1'b1;
        end else begin
          state_d = last_q ? S_CHECK : S_IDLE;
        end
      end
      S_CHIW: begin
        if (!wait_q && !sts_i.div_busy) begin
          cmd_o.chi_add = 1'b1;
          state_d = last_q ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_MULW;
      end
      S_MULW: begin
        cmd_o.div_sel = DSEL_CORR;
        if (!sts_i.mul_busy) begin
          cmd_o.div_start = !sts_i.count_zero;
          wait_d  = 1'b1;
          state_d = S_CORRW;
        end
      end
      S_CORRW: begin
        cmd_o.div_sel = DSEL_CORR;
        if (!wait_q && !sts_i.div_busy) begin
          cmd_o.tss_calc = 1'b1;
          state_d = S_TSS;
        end
      end
      S_TSS: begin
        if (sts_i.tss_zero || sts_i.rss_ge_tss) begin
          state_d = S_OUT;
        end else begin
          cmd_o.r2_prep = 1'b1;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.div_sel = DSEL_R2;
        if (sts_i.norm_done) begin
          cmd_o.div_start = 1'b1;
          wait_d  = 1'b1;
          state_d = S_R2W;
        end else begin
          cmd_o.r2_prep = 1'b1;
        end
      end
      S_R2W: begin
        cmd_o.div_sel = DSEL_R2;
        if (!wait_q && !sts_i.div_busy) begin
          cmd_o.r2_done = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          cmd_o.emit  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      wait_q  <= wait_d;
    end
  end

  a_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while result pending");
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

endmodule

// ----- rtl/goodness_of_fit_chi_square_r2_unit.sv -----
// each pair is latched and added, with a chi division on the 128-step shared divider if
// expected > floor; a last pair then squares the observed sum, divides the correction,
// forms tss, normalizes (n <= 16 shifts) and divides r2, skipping both if r2 is zeroed
// throughput: one request at a time, input stalls while a result waits
// reset: asynchronous active low, clears accumulators, floor returns to 66
// depends on gof_pkg, gof_ctrl, gof_datapath, gof_divider
module goodness_of_fit_chi_square_r2_unit #(
  parameter int unsigned MAX_PAIRS = 512,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gof_pkg::DataW-1:0]     observed_i,
  input  logic [gof_pkg::DataW-1:0]     expected_i,
  input  logic                          last_pair_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gof_pkg::AccW-1:0]      chi_square_o,
  output logic [gof_pkg::R2W-1:0]       r_squared_o,
  output logic [gof_pkg::CntW-1:0]      pairs_used_o,
  output logic                          degenerate_o
);
  import gof_pkg::*;

  logic [DataW-1:0] floor_q;
  gof_cmd_t         cmd;
  gof_sts_t         sts;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr == 2'(4 * REG_EXPECTED_FLOOR));
  assign prdata  = reg_hit ? floor_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FloorReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      floor_q <= pwdata;
    end
  end

  gof_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .last_pair_i(last_pair_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gof_datapath #(.MaxPairs(MAX_PAIRS), .FracBits(FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .observed_i  (observed_i),
    .expected_i  (expected_i),
    .floor_i     (floor_q),
    .chi_square_o(chi_square_o),
    .r_squared_o (r_squared_o),
    .pairs_used_o(pairs_used_o),
    .degenerate_o(degenerate_o)
  );

endmodule

// ----- dv/goodness_of_fit_chi_square_r2_unit_test.sv -----
// self-checking testbench for goodness_of_fit_chi_square_r2_unit: series of
// observed/expected requests against a built-in chi-square / r2 predictor
// depends on gof_pkg and the goodness_of_fit_chi_square_r2_unit rtl
`timescale 1ns / 100ps

module goodness_of_fit_chi_square_r2_unit_test;
  import gof_pkg::*;

  localparam int unsigned MaxPairs = 512;
  localparam int unsigned Frac = 16;
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned HoldCycles = 2500;
  localparam int unsigned SettleCycles = 400;

  typedef struct {
    logic [DataW-1:0] observed;
    logic [DataW-1:0] expected;
    logic             last;
  } pair_t;

  typedef struct {
    logic [AccW-1:0] chi;
    logic [R2W-1:0]  r2;
    logic [CntW-1:0] used;
    logic            degen;
  } fit_t;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_RECV_LIGHT,
    IDLE_NONE
  } idle_mode_e;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, last_pair_i;
  logic [DataW-1:0] observed_i, expected_i;
  logic out_valid_o, out_ready_i, degenerate_o;
  logic [AccW-1:0] chi_square_o;
  logic [R2W-1:0] r_squared_o;
  logic [CntW-1:0] pairs_used_o;

  goodness_of_fit_chi_square_r2_unit u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .observed_i, .expected_i, .last_pair_i,
    .out_valid_o, .out_ready_i, .chi_square_o, .r_squared_o, .pairs_used_o,
    .degenerate_o
  );

  pair_t pair_q[$];
  fit_t fit_q[$];
  idle_mode_e idle_mode = IDLE_SEND_LIGHT;
  int unsigned errors = 0, n_accepted = 0, n_results = 0, n_series = 0;
  int unsigned n_pushed = 0, cycles = 0, hold_cnt = 0;
  bit hold_req = 0, hold_seen = 0;

  // predictor state
  logic [31:0] floor_m = FloorReset;
  int unsigned count_m = 0;
  logic [63:0] osum_m = 0, osq_m = 0, rss_m = 0, chi_m = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("goodness_of_fit_chi_square_r2_unit_test: errors");
      $finish;
    end
  end

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic void predict_pair(pair_t p);
    logic [63:0] d, d2, corr, tss, num, den;
    logic [127:0] sq;
    logic [79:0] r2w;
    fit_t r;
    if (count_m < MaxPairs) begin
      d = (p.observed >= p.expected) ? 64'(p.observed) - 64'(p.expected)
                                     : 64'(p.expected) - 64'(p.observed);
      d2 = d * d;
      count_m++;
      osum_m = osum_m + 64'(p.observed);
      if (osum_m > Mask48) osum_m = Mask48;
      osq_m = sat_add(osq_m, (64'(p.observed) * 64'(p.observed)) >> Frac);
      rss_m = sat_add(rss_m, d2 >> Frac);
      if (p.expected > floor_m) chi_m = sat_add(chi_m, d2 / 64'(p.expected));
    end
    if (!p.last) return;
    tss = 0;
    if (count_m != 0) begin
      sq = ((128'(osum_m) * 128'(osum_m)) >> Frac) / 128'(count_m);
      corr = (sq[127:64] != 0) ? '1 : sq[63:0];
      tss = (osq_m > corr) ? osq_m - corr : 64'd0;
    end
    r.r2 = 0;
    r.degen = (tss == 0);
    if (tss != 0 && rss_m < tss) begin
      num = tss - rss_m;
      den = tss;
      while (den > Mask48) begin
        den >>= 1;
        num >>= 1;
      end
      r2w = (80'(num) << R2Frac) / 80'(den);
      if (r2w > (80'd1 << R2Frac)) r2w = 80'd1 << R2Frac;
      r.r2 = r2w[R2W-1:0];
    end
    r.chi = chi_m;
    r.used = count_m[CntW-1:0];
    fit_q.push_back(r);
    count_m = 0;
    osum_m = 0;
    osq_m = 0;
    rss_m = 0;
    chi_m = 0;
  endfunction

  function automatic bit send_idle();
    case (idle_mode)
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 24;
      IDLE_RECV_LIGHT: return $urandom_range(0, 99) < 60;
      default:         return 0;
    endcase
  endfunction

  function automatic bit recv_idle();
    case (idle_mode)
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 60;
      IDLE_RECV_LIGHT: return $urandom_range(0, 99) < 24;
      default:         return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      observed_i <= 0;
      expected_i <= 0;
      last_pair_i <= 0;
    end else begin : drive
      pair_t p;
      if (in_valid_i && in_ready_o) begin
        p.observed = observed_i;
        p.expected = expected_i;
        p.last = last_pair_i;
        predict_pair(p);
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pair_q.size() > 0 && !send_idle()) begin
          p = pair_q.pop_front();
          in_valid_i <= 1;
          observed_i <= p.observed;
          expected_i <= p.expected;
          last_pair_i <= p.last;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", n_results, field, got, want);
    errors++;
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
    end else begin : watch
      fit_t w;
      if (out_valid_o && out_ready_i) begin
        if (fit_q.size() == 0) begin
          report("unexpected result", chi_square_o, 64'd0);
        end else begin
          w = fit_q.pop_front();
          if (chi_square_o !== w.chi) report("chi_square", chi_square_o, w.chi);
          if (r_squared_o !== w.r2) report("r_squared", 64'(r_squared_o), 64'(w.r2));
          if (pairs_used_o !== w.used) report("pairs_used", 64'(pairs_used_o), 64'(w.used));
          if (degenerate_o !== w.degen) report("degenerate", 64'(degenerate_o), 64'(w.degen));
        end
        n_results++;
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt <= HoldCycles;
        out_ready_i <= 0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= !recv_idle();
      end
    end
  end

  task automatic wait_drained();
    while (pair_q.size() != 0 || in_valid_i || fit_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_floor(logic [31:0] v);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 2'(4 * REG_EXPECTED_FLOOR);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    floor_m = v;
  endtask

  task automatic push(logic [31:0] o, logic [31:0] e, logic last);
    pair_t p;
    p.observed = o;
    p.expected = e;
    p.last = last;
    pair_q.push_back(p);
    n_pushed++;
    if (last) n_series++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      3: return $urandom_range(32'h0000_8000, 32'h0002_0000);
      4: return $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_expected(logic [31:0] o);
    case ($urandom_range(0, 11))
      0: return 0;
      1: return floor_m;
      2: return floor_m + 1;
      3: return o;
      4: return o + $urandom_range(0, 4096) - 2048;
      default: return pick_value();
    endcase
  endfunction

  task automatic push_series(int unsigned len);
    logic [31:0] o, flat;
    bit same;
    same = ($urandom_range(0, 9) == 0);
    flat = pick_value();
    for (int unsigned i = 0; i < len; i++) begin
      o = same ? flat : pick_value();
      push(o, pick_expected(o), i == len - 1);
    end
  endtask

  task automatic random_phase(int unsigned quota, bit with_hold);
    int unsigned start;
    start = n_pushed;
    if (with_hold) begin
      hold_req <= ~hold_req;
      for (int i = 0; i < 20; i++) push_series($urandom_range(1, 3));
    end
    while (n_pushed - start < quota) begin
      if ($urandom_range(0, 19) == 0) push($urandom, $urandom, 1);
      else if ($urandom_range(0, 29) == 0)
        push(32'h0, 32'h0, $urandom_range(0, 1));
      else push_series($urandom_range(1, 12));
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extremes, floor edges, single pair, flat series, saturation
    push(32'h0001_0000, 32'h0001_0000, 1);
    push(32'hFFFF_FFFF, 32'h0000_0001, 0);
    push(32'hFFFF_FFFF, 32'h0000_0001, 0);
    push(32'h0000_0000, 32'hFFFF_FFFF, 1);
    push(32'h0002_0000, 32'd0, 0);
    push(32'h0003_0000, 32'd66, 0);
    push(32'h0004_0000, 32'd67, 1);
    push(32'h0005_0000, 32'h0005_0000, 0);
    push(32'h0005_0000, 32'h0005_0000, 1);
    push(32'h0001_0000, 32'h0001_8000, 0);
    push(32'h0002_0000, 32'h0002_0000, 0);
    push(32'h0003_0000, 32'h0002_8000, 1);
    push(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    push(32'h0000_0000, 32'h0000_0000, 1);
    push(32'hAAAA_5555, 32'h5555_AAAA, 1);
    wait_drained();

    // too many pairs: 530 in one series, no chi terms to keep it quick
    write_floor(32'hFFFF_FFFF);
    for (int i = 0; i < 530; i++) push($urandom, $urandom_range(0, 1) ? 0 : $urandom, i == 529);
    wait_drained();

    write_floor(32'h0000_0000);
    idle_mode = IDLE_SEND_LIGHT;
    random_phase(300, 0);
    write_floor($urandom);
    idle_mode = IDLE_RECV_LIGHT;
    random_phase(250, 0);
    write_floor(32'd66);
    idle_mode = IDLE_NONE;
    random_phase(300, 1);

    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d requests in %0d series, %0d results checked", n_accepted, n_series,
             n_results);
    $display("floor settings: reset, all ones, zero, random, 66; long receiver hold included");
    if (errors == 0 && fit_q.size() == 0) begin
      $display("goodness_of_fit_chi_square_r2_unit_test: clean");
    end else begin
      $display("goodness_of_fit_chi_square_r2_unit_test: errors");
    end
    $finish;
  end

endmodule
